>>> rtl/indicator_led_animator_macros.svh
// ----------------------------------------------------------------------------
// Indicator LED animator assertion macros
// Shared wrappers for the concurrent checks of the animator.
// ----------------------------------------------------------------------------
`ifndef INDICATOR_LED_ANIMATOR_MACROS_SVH
`define INDICATOR_LED_ANIMATOR_MACROS_SVH

// Check a property on the rising clock edge, off while reset is low.
`define ILA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an event implies a property on the following edge.
`define ILA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ila_pkg.sv
// ----------------------------------------------------------------------------
// Indicator LED animator package
// Opcodes, modes, colors, controller states and control structs.
// ----------------------------------------------------------------------------
package ila_pkg;

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_BAR  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] MODE_STEADY = 2'd0;
  localparam logic [1:0] MODE_FAST   = 2'd1;
  localparam logic [1:0] MODE_SLOW   = 2'd2;
  localparam logic [1:0] MODE_FADE   = 2'd3;

  localparam logic [23:0] COLOR_RED   = 24'hFF0000;
  localparam logic [23:0] COLOR_GREEN = 24'h008000;
  localparam logic [23:0] COLOR_BLACK = 24'h000000;

  localparam int         SEG_STEP        = 10;
  localparam logic [7:0] FADE_LO         = 8'd10;
  localparam logic [7:0] FADE_HI         = 8'd245;
  localparam logic [7:0] SLOW_PERIOD_RST = 8'd10;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TICK = 3'b010,
    ST_EMIT = 3'b100
  } ila_state_e;

  typedef struct packed {
    logic load;  // capture the input item
    logic clr;   // restart the pixel counter
    logic upd;   // animate the indicator at the counter
    logic emit;  // load the output register with the pixel at the counter
  } ila_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic last_ind;
    logic last_px;
    logic out_free;
  } ila_sts_t;

endpackage

>>> rtl/ila_ctrl.sv
// ----------------------------------------------------------------------------
// Indicator LED animator controller
// Sequences capture, per-indicator animation and the frame readout.
// ----------------------------------------------------------------------------
module ila_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ila_pkg::ila_sts_t sts_i,
  output ila_pkg::ila_cmd_t cmd_o
);
  import ila_pkg::*;

  ila_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.clr  = 1'b1;
          state_d    = sts_i.is_tick ? ST_TICK : ST_EMIT;
        end
      end
      ST_TICK: begin
        cmd_o.upd = 1'b1;
        if (sts_i.last_ind) begin
          cmd_o.clr = 1'b1;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_px) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/ila_dp.sv
// ----------------------------------------------------------------------------
// Indicator LED animator datapath
// Indicator and bar state, blink phases, fade scaler and the output register.
// ----------------------------------------------------------------------------
module ila_dp #(
  parameter int BAR_SEGMENTS    = 10,
  parameter int INDICATOR_COUNT = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ila_pkg::ila_cmd_t cmd_i,
  output ila_pkg::ila_sts_t sts_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  input  logic [1:0]        op_i,
  input  logic [1:0]        indicator_i,
  input  logic [23:0]       color_i,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        start_level_i,
  input  logic signed [7:0] fade_step_i,
  input  logic signed [7:0] port_power_i,
  input  logic signed [7:0] starboard_power_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [4:0]        pixel_index_o,
  output logic [23:0]       pixel_color_o,
  output logic              frame_end_o
);
  import ila_pkg::*;

  localparam int FrameLen = INDICATOR_COUNT + 2 * BAR_SEGMENTS;
  localparam int IdxW     = $clog2(FrameLen);
  localparam int IndW     = (INDICATOR_COUNT > 1) ? $clog2(INDICATOR_COUNT) : 1;
  localparam int ThrW     = $clog2(SEG_STEP * BAR_SEGMENTS + 1);
  localparam int CmpW     = (ThrW + 1 > 8) ? ThrW + 1 : 8;

  logic [7:0]  slow_period_q;
  logic [7:0]  tick_count_q;
  logic        fast_q;
  logic        slow_q;
  logic [23:0] ind_color_q [INDICATOR_COUNT];
  logic [1:0]  ind_mode_q  [INDICATOR_COUNT];
  logic [7:0]  level_q     [INDICATOR_COUNT];
  logic [7:0]  delta_q     [INDICATOR_COUNT];
  logic [23:0] ind_px_q    [INDICATOR_COUNT];
  logic signed [7:0] port_q;
  logic signed [7:0] stbd_q;
  logic [IdxW-1:0]   idx_q;

  logic        out_valid_q;
  logic [4:0]  pix_idx_q;
  logic [23:0] pix_color_q;
  logic        frame_end_q;

  // Tick counter and phases
  logic [7:0] tc_inc;
  logic       roll;
  assign tc_inc = tick_count_q + 8'd1;
  assign roll   = (tc_inc >= slow_period_q);

  // Indicator at the counter, shared fade scaler
  logic [IndW-1:0] sel;
  logic [23:0]     sel_color;
  logic [1:0]      sel_mode;
  logic [7:0]      sel_level;
  logic [7:0]      sel_delta;
  logic [8:0]      k9;
  logic [16:0]     prod_r, prod_g, prod_b;
  logic [23:0]     scaled;
  logic [7:0]      new_level;
  logic            flip;
  logic [7:0]      new_delta;
  logic [23:0]     upd_px;

  assign sel       = idx_q[IndW-1:0];
  assign sel_color = ind_color_q[sel];
  assign sel_mode  = ind_mode_q[sel];
  assign sel_level = level_q[sel];
  assign sel_delta = delta_q[sel];
  assign k9        = {1'b0, sel_level} + 9'd1;
  assign prod_r    = 17'(sel_color[23:16]) * 17'(k9);
  assign prod_g    = 17'(sel_color[15:8])  * 17'(k9);
  assign prod_b    = 17'(sel_color[7:0])   * 17'(k9);
  assign scaled    = {prod_r[15:8], prod_g[15:8], prod_b[15:8]};
  assign new_level = sel_level + sel_delta;
  assign flip      = (new_level <= FADE_LO) || (new_level >= FADE_HI);
  assign new_delta = flip ? (8'd0 - sel_delta) : sel_delta;

  always_comb begin
    case (sel_mode)
      MODE_FAST: upd_px = fast_q ? sel_color : COLOR_BLACK;
      MODE_SLOW: upd_px = slow_q ? sel_color : COLOR_BLACK;
      MODE_FADE: upd_px = scaled;
      default:   upd_px = ind_px_q[sel];
    endcase
  end

  // Pixel at the counter: indicator, or a bar segment lit by threshold
  logic [IdxW-1:0]       seg;
  logic signed [7:0]     bar_v;
  logic [ThrW-1:0]       thr;
  logic signed [CmpW-1:0] v_ext;
  logic signed [CmpW-1:0] thr_s;
  logic [23:0]           px_color;

  always_comb begin
    bar_v = port_q;
    seg   = idx_q - IdxW'(INDICATOR_COUNT);
    if (idx_q >= IdxW'(INDICATOR_COUNT + BAR_SEGMENTS)) begin
      bar_v = stbd_q;
      seg   = idx_q - IdxW'(INDICATOR_COUNT + BAR_SEGMENTS);
    end
    thr   = ThrW'(ThrW'(seg) * ThrW'(SEG_STEP) + ThrW'(SEG_STEP));
    v_ext = CmpW'(bar_v);
    thr_s = signed'(CmpW'(thr));
    if (idx_q < IdxW'(INDICATOR_COUNT)) begin
      px_color = ind_px_q[sel];
    end else if (v_ext >= thr_s) begin
      px_color = COLOR_RED;
    end else if (v_ext <= -thr_s) begin
      px_color = COLOR_GREEN;
    end else begin
      px_color = COLOR_BLACK;
    end
  end

  assign sts_o.is_tick  = (op_i == OP_TICK);
  assign sts_o.last_ind = (idx_q == IdxW'(INDICATOR_COUNT - 1));
  assign sts_o.last_px  = (idx_q == IdxW'(FrameLen - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_period_q <= SLOW_PERIOD_RST;
      tick_count_q  <= '0;
      fast_q        <= 1'b0;
      slow_q        <= 1'b0;
      port_q        <= '0;
      stbd_q        <= '0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < INDICATOR_COUNT; i++) begin
        ind_color_q[i] <= '0;
        ind_mode_q[i]  <= MODE_STEADY;
        level_q[i]     <= '0;
        delta_q[i]     <= '0;
        ind_px_q[i]    <= COLOR_BLACK;
      end
    end else begin
      if (cfg_we_i) begin
        slow_period_q <= cfg_data_i;
      end
      if (cmd_i.load && op_i == OP_BAR) begin
        port_q <= port_power_i;
        stbd_q <= starboard_power_i;
      end
      if (cmd_i.load && op_i == OP_TICK) begin
        fast_q       <= ~fast_q;
        tick_count_q <= roll ? 8'd0 : tc_inc;
        if (roll) begin
          slow_q <= ~slow_q;
        end
      end
      for (int i = 0; i < INDICATOR_COUNT; i++) begin
        if (cmd_i.load && op_i == OP_SET && 32'(indicator_i) == i) begin
          ind_color_q[i] <= color_i;
          ind_mode_q[i]  <= mode_i;
          level_q[i]     <= start_level_i;
          delta_q[i]     <= fade_step_i;
          ind_px_q[i]    <= color_i;
        end
        if (cmd_i.upd && 32'(idx_q) == i) begin
          ind_px_q[i] <= upd_px;
          if (sel_mode == MODE_FADE) begin
            level_q[i] <= new_level;
            delta_q[i] <= new_delta;
          end
        end
      end
      if (cmd_i.clr) begin
        idx_q <= '0;
      end else if (cmd_i.upd || cmd_i.emit) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pix_idx_q   <= 5'(idx_q);
      pix_color_q <= px_color;
      frame_end_q <= sts_o.last_px;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = pix_idx_q;
  assign pixel_color_o = pix_color_q;
  assign frame_end_o   = frame_end_q;

endmodule

>>> rtl/indicator_led_animator.sv
// ----------------------------------------------------------------------------
// Indicator LED animator: 3 indicator pixels and two power bars, whole frame out
// Order: a tick first animates each indicator, then the frame is read out.
// Throughput: one pixel a cycle unless the output stalls; no new item mid-frame.
// Reset: all pixels black, indicators steady, phases and tick count 0, slow_period 10.
// ----------------------------------------------------------------------------
module indicator_led_animator #(
  parameter int BAR_SEGMENTS    = 10,
  parameter int INDICATOR_COUNT = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [1:0]        indicator_i,
  input  logic [23:0]       color_i,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        start_level_i,
  input  logic signed [7:0] fade_step_i,
  input  logic signed [7:0] port_power_i,
  input  logic signed [7:0] starboard_power_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [4:0]        pixel_index_o,
  output logic [23:0]       pixel_color_o,
  output logic              frame_end_o
);
  import ila_pkg::*;

  ila_cmd_t cmd;
  ila_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ila_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ila_dp #(
    .BAR_SEGMENTS    (BAR_SEGMENTS),
    .INDICATOR_COUNT (INDICATOR_COUNT)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .indicator_i       (indicator_i),
    .color_i           (color_i),
    .mode_i            (mode_i),
    .start_level_i     (start_level_i),
    .fade_step_i       (fade_step_i),
    .port_power_i      (port_power_i),
    .starboard_power_i (starboard_power_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .pixel_index_o     (pixel_index_o),
    .pixel_color_o     (pixel_color_o),
    .frame_end_o       (frame_end_o)
  );

endmodule

>>> rtl/ila_checker.sv
// ----------------------------------------------------------------------------
// Indicator LED animator checker
// Port-level checks on item intake and frame readout order.
// ----------------------------------------------------------------------------
`include "indicator_led_animator_macros.svh"

module ila_checker #(
  parameter int BAR_SEGMENTS    = 10,
  parameter int INDICATOR_COUNT = 3
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  pixel_index_o,
  input logic        frame_end_o
);
  localparam int FrameLen = INDICATOR_COUNT + 2 * BAR_SEGMENTS;

  // One item at a time: intake closes right after a beat
  `ILA_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "intake open after beat")

  // Pixels leave back to back in index order within a frame
  `ILA_ASSERT_NEXT(a_next_pixel, clk_i, rst_ni, out_valid_o && out_ready_i && !frame_end_o, out_valid_o && pixel_index_o == 5'($past(pixel_index_o) + 5'd1), "pixel order broken")

  // Frame end marks the last pixel only
  `ILA_ASSERT(a_frame_end_idx, clk_i, rst_ni, out_valid_o |-> (frame_end_o == (pixel_index_o == 5'(FrameLen - 1))), "frame end on wrong pixel")

  // Intake stays closed while a pixel before the frame end waits on the receiver
  `ILA_ASSERT_NEXT(a_no_intake_mid, clk_i, rst_ni, out_valid_o && !out_ready_i && !frame_end_o, !in_ready_o, "intake open mid frame")

endmodule

bind indicator_led_animator ila_checker #(
  .BAR_SEGMENTS    (BAR_SEGMENTS),
  .INDICATOR_COUNT (INDICATOR_COUNT)
) u_ila_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_index_o (pixel_index_o),
  .frame_end_o   (frame_end_o)
);

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Indicator LED animator testbench
// Drives set, power-bar, tick and unused items through the input channel and
// predicts every pixel of each emitted frame with a local copy of the animator
// state. The slow period is rewritten between phases while the block is idle.
// Each phase uses its own input-gap and output-stall mix. One phase holds the
// output off for a long stretch, and one drains all pixels before going on.
// ----------------------------------------------------------------------------
module tb;
  import ila_pkg::*;

  localparam int IND_N       = 3;
  localparam int SEGS        = 10;
  localparam int FRAME_LEN   = IND_N + 2 * SEGS;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct {
    logic [1:0]        op;
    logic [1:0]        indicator;
    logic [23:0]       color;
    logic [1:0]        mode;
    logic [7:0]        start_level;
    logic signed [7:0] fade_step;
    logic signed [7:0] port_power;
    logic signed [7:0] starboard_power;
  } led_item_t;

  typedef struct {
    logic [4:0]  index;
    logic [23:0] color;
    logic        last;
  } pixel_t;

  class pixel_frame_model;
    logic [23:0] frame [FRAME_LEN];
    logic [23:0] ind_color [IND_N];
    logic [1:0]  ind_mode [IND_N];
    logic [7:0]  fade_lvl [IND_N];
    logic [7:0]  fade_dlt [IND_N];
    logic [7:0]  tick_cnt;
    logic [7:0]  slow_period;
    logic        fast_ph;
    logic        slow_ph;
    pixel_t      pending_pixels [$];
    int          errors;

    function new();
      foreach (frame[k]) frame[k] = COLOR_BLACK;
      for (int i = 0; i < IND_N; i++) begin
        ind_color[i] = '0;
        ind_mode[i]  = MODE_STEADY;
        fade_lvl[i]  = '0;
        fade_dlt[i]  = '0;
      end
      tick_cnt    = '0;
      slow_period = SLOW_PERIOD_RST;
      fast_ph     = 1'b0;
      slow_ph     = 1'b0;
      errors      = 0;
    endfunction

    function void fill_bar(int base, logic signed [7:0] power);
      int left;
      left = power;
      for (int i = 0; i < SEGS; i++) begin
        if (left >= SEG_STEP) begin
          frame[base + i] = COLOR_RED;
          left -= SEG_STEP;
        end else if (left <= -SEG_STEP) begin
          frame[base + i] = COLOR_GREEN;
          left += SEG_STEP;
        end else begin
          frame[base + i] = COLOR_BLACK;
        end
      end
    endfunction

    // Scale each channel by (level + 1) / 256.
    function logic [23:0] dim(logic [23:0] c, logic [7:0] lvl);
      logic [23:0] res;
      logic [16:0] prod;
      res = '0;
      for (int ch = 0; ch < 3; ch++) begin
        prod = c[ch*8 +: 8] * ({1'b0, lvl} + 9'd1);
        res[ch*8 +: 8] = prod[15:8];
      end
      return res;
    endfunction

    function void advance_tick();
      tick_cnt = tick_cnt + 8'd1;
      fast_ph  = ~fast_ph;
      if (tick_cnt >= slow_period) begin
        tick_cnt = '0;
        slow_ph  = ~slow_ph;
      end
      for (int i = 0; i < IND_N; i++) begin
        case (ind_mode[i])
          MODE_FAST: frame[i] = fast_ph ? ind_color[i] : COLOR_BLACK;
          MODE_SLOW: frame[i] = slow_ph ? ind_color[i] : COLOR_BLACK;
          MODE_FADE: begin
            frame[i]    = dim(ind_color[i], fade_lvl[i]);
            fade_lvl[i] = fade_lvl[i] + fade_dlt[i];
            // Reverse near either end; -128 negates to itself.
            if (fade_lvl[i] <= FADE_LO || fade_lvl[i] >= FADE_HI)
              fade_dlt[i] = 8'd0 - fade_dlt[i];
          end
          default: ;
        endcase
      end
    endfunction

    function void apply_item(led_item_t it);
      pixel_t px;
      case (it.op)
        OP_SET: begin
          if (it.indicator < IND_N) begin
            ind_color[it.indicator] = it.color;
            ind_mode[it.indicator]  = it.mode;
            fade_lvl[it.indicator]  = it.start_level;
            fade_dlt[it.indicator]  = it.fade_step;
            frame[it.indicator]     = it.color;
          end
        end
        OP_BAR: begin
          fill_bar(IND_N, it.port_power);
          fill_bar(IND_N + SEGS, it.starboard_power);
        end
        OP_TICK: advance_tick();
        default: ;
      endcase
      for (int k = 0; k < FRAME_LEN; k++) begin
        px.index = 5'(k);
        px.color = frame[k];
        px.last  = (k == FRAME_LEN - 1);
        pending_pixels.push_back(px);
      end
    endfunction

    function void check_pixel(logic [4:0] idx, logic [23:0] col, logic last);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: pixel %0d color %06h arrived with nothing pending", $time, idx, col);
        return;
      end
      want = pending_pixels.pop_front();
      if (idx !== want.index) begin
        errors++;
        $display("%0t: pixel_index expected %0d actual %0d", $time, want.index, idx);
      end
      if (col !== want.color) begin
        errors++;
        $display("%0t: pixel %0d color expected %06h actual %06h",
                 $time, want.index, want.color, col);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: pixel %0d frame_end expected %0b actual %0b",
                 $time, want.index, want.last, last);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        op_i = '0;
  logic [1:0]        indicator_i = '0;
  logic [23:0]       color_i = '0;
  logic [1:0]        mode_i = '0;
  logic [7:0]        start_level_i = '0;
  logic signed [7:0] fade_step_i = '0;
  logic signed [7:0] port_power_i = '0;
  logic signed [7:0] starboard_power_i = '0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [7:0]        cfg_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [4:0]        pixel_index_o;
  logic [23:0]       pixel_color_o;
  logic              frame_end_o;

  pixel_frame_model frames = new();

  int          snd_idle_pct  = 0;
  int          rcv_stall_pct = 0;
  int          stall_orders  = 0;
  int          stall_seen    = 0;
  int          stall_left    = 0;
  int unsigned cycle_count   = 0;

  indicator_led_animator #(
    .BAR_SEGMENTS    (SEGS),
    .INDICATOR_COUNT (IND_N)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .indicator_i       (indicator_i),
    .color_i           (color_i),
    .mode_i            (mode_i),
    .start_level_i     (start_level_i),
    .fade_step_i       (fade_step_i),
    .port_power_i      (port_power_i),
    .starboard_power_i (starboard_power_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pixel_index_o     (pixel_index_o),
    .pixel_color_o     (pixel_color_o),
    .frame_end_o       (frame_end_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Pixel receiver: check each beat, then pick ready for the next cycle.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        frames.check_pixel(pixel_index_o, pixel_color_o, frame_end_o);
      @(negedge clk_i);
      if (stall_seen != stall_orders) begin
        stall_seen = stall_orders;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  function automatic led_item_t mk_set(logic [1:0] ind, logic [23:0] col, logic [1:0] md,
                                       logic [7:0] lvl, logic signed [7:0] step);
    led_item_t it;
    it = '{op: OP_SET, indicator: ind, color: col, mode: md, start_level: lvl,
           fade_step: step, port_power: '0, starboard_power: '0};
    return it;
  endfunction

  function automatic led_item_t mk_bar(logic signed [7:0] port, logic signed [7:0] stbd);
    led_item_t it;
    it = '{op: OP_BAR, indicator: '0, color: '0, mode: MODE_STEADY, start_level: '0,
           fade_step: '0, port_power: port, starboard_power: stbd};
    return it;
  endfunction

  function automatic led_item_t mk_op(logic [1:0] op);
    led_item_t it;
    it = '{op: op, indicator: '0, color: '0, mode: MODE_STEADY, start_level: '0,
           fade_step: '0, port_power: '0, starboard_power: '0};
    return it;
  endfunction

  function automatic led_item_t random_item();
    led_item_t it;
    int        r;
    r = $urandom_range(0, 99);
    it.op = (r < 40) ? OP_TICK : (r < 70) ? OP_SET : (r < 92) ? OP_BAR : OP_UNUSED;
    it.indicator = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, IND_N - 1));
    it.color = 24'($urandom);
    it.mode = 2'($urandom);
    it.start_level = 8'($urandom);
    // Mostly small steps so fades bounce between the turn points.
    if ($urandom_range(0, 2) == 0) begin
      it.fade_step = 8'($urandom);
    end else begin
      it.fade_step = 8'($urandom_range(1, 24));
      if ($urandom_range(0, 1) == 1) it.fade_step = -it.fade_step;
    end
    it.port_power = 8'($urandom);
    it.starboard_power = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(led_item_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    op_i              = it.op;
    indicator_i       = it.indicator;
    color_i           = it.color;
    mode_i            = it.mode;
    start_level_i     = it.start_level;
    fade_step_i       = it.fade_step;
    port_power_i      = it.port_power;
    starboard_power_i = it.starboard_power;
    in_valid_i        = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    frames.apply_item(it);
  endtask

  // Drop valid, wait for every pending pixel, then let the block go quiet.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (frames.pending_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_slow_period(logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    frames.slow_period = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    logic [7:0] periods [4];
    int         snd_pcts [4];
    int         rcv_pcts [4];
    periods  = '{8'd1, 8'd0, 8'd255, 8'd4};
    snd_pcts = '{0, 48, 0, 23};
    rcv_pcts = '{0, 0, 48, 23};
    periods[3] = 8'($urandom_range(2, 12));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: bar extremes and thresholds, every mode, ignored set and op,
    // fade wrap, fade step of -128, and a reversal at the top turn point.
    send_item(mk_bar(8'sd127, -8'sd128));
    send_item(mk_bar(-8'sd128, 8'sd127));
    send_item(mk_bar(8'sd9, -8'sd9));
    send_item(mk_bar(8'sd10, -8'sd10));
    send_item(mk_bar(8'sd0, 8'sd55));
    send_item(mk_set(2'd0, 24'hFFFFFF, MODE_STEADY, 8'd0, 8'sd0));
    send_item(mk_set(2'd1, 24'h123456, MODE_FAST, 8'd0, 8'sd0));
    send_item(mk_set(2'd2, 24'hABCDEF, MODE_SLOW, 8'd0, 8'sd0));
    send_item(mk_set(2'd3, 24'h00FF00, MODE_FADE, 8'hFF, 8'sd127));
    send_item(mk_op(OP_UNUSED));
    repeat (3) send_item(mk_op(OP_TICK));
    send_item(mk_set(2'd0, 24'hFFFFFF, MODE_FADE, 8'd250, 8'sd127));
    send_item(mk_set(2'd1, 24'h80FF01, MODE_FADE, 8'd0, -8'sd128));
    send_item(mk_set(2'd2, 24'h00FF00, MODE_FADE, 8'd240, 8'sd5));
    repeat (8) send_item(mk_op(OP_TICK));

    for (int p = 0; p < 4; p++) begin
      settle();
      write_slow_period(periods[p]);
      snd_idle_pct  = snd_pcts[p];
      rcv_stall_pct = rcv_pcts[p];
      if (p == 0) begin
        // Hold the output off and keep offering beats until input stalls.
        stall_orders++;
        repeat (12) send_item(random_item());
      end
      repeat (35) send_item(random_item());
      if (p == 1) settle();
      repeat (35) send_item(random_item());
    end

    settle();
    if (frames.errors == 0 && frames.pending_pixels.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/ila_pkg.sv
rtl/ila_ctrl.sv
rtl/ila_dp.sv
rtl/indicator_led_animator.sv
rtl/ila_checker.sv
verif/tb.sv
